/* hdl/rmf_pkg.sv */
// Shared types, register codes and median-network functions for the RGB 3x3 median filter.
// No dependencies; imported by rgb_median_3x3_filter.
package rmf_pkg;

   localparam int CHAN_W         = 8;
   localparam int FRAME_WIDTH_W  = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int CENTRE_COL_W   = 10;
   localparam int ROW_W          = 12;
   localparam int MIN_FRAME      = 3;

   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 12'd480;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } pixel_type;

   // Both line stores share one address, so one entry holds the upper and the middle pixel.
   typedef struct packed {
      pixel_type upper;
      pixel_type middle;
   } line_entry_type;

   typedef struct packed {
      logic [CENTRE_COL_W-1:0] column;
      logic [ROW_W-1:0]        row;
      logic                    last;
   } centre_type;

   typedef logic [8:0][CHAN_W-1:0] chan9_type;

   typedef struct packed {
      chan9_type red;
      chan9_type green;
      chan9_type blue;
   } window_chan_type;

   // Compare-exchange: afterwards v[a] <= v[b].
   function automatic chan9_type cmp_swap(chan9_type v, logic [3:0] a, logic [3:0] b);
      logic [CHAN_W-1:0] t;
      t = v[a];
      if (v[a] > v[b]) begin
         v[a] = v[b];
         v[b] = t;
      end
      return v;
   endfunction

   // The nineteen exchanges of the median-of-nine network are split into three
   // groups, one per pipeline stage. The median ends up in element four.
   function automatic chan9_type med_layers_a(chan9_type v);
      v = cmp_swap(v, 4'd1, 4'd2);
      v = cmp_swap(v, 4'd4, 4'd5);
      v = cmp_swap(v, 4'd7, 4'd8);
      v = cmp_swap(v, 4'd0, 4'd1);
      v = cmp_swap(v, 4'd3, 4'd4);
      v = cmp_swap(v, 4'd6, 4'd7);
      v = cmp_swap(v, 4'd1, 4'd2);
      v = cmp_swap(v, 4'd4, 4'd5);
      v = cmp_swap(v, 4'd7, 4'd8);
      return v;
   endfunction

   function automatic chan9_type med_layers_b(chan9_type v);
      v = cmp_swap(v, 4'd0, 4'd3);
      v = cmp_swap(v, 4'd5, 4'd8);
      v = cmp_swap(v, 4'd4, 4'd7);
      v = cmp_swap(v, 4'd3, 4'd6);
      v = cmp_swap(v, 4'd1, 4'd4);
      v = cmp_swap(v, 4'd2, 4'd5);
      v = cmp_swap(v, 4'd4, 4'd7);
      return v;
   endfunction

   function automatic logic [CHAN_W-1:0] med_layers_c(chan9_type v);
      v = cmp_swap(v, 4'd4, 4'd2);
      v = cmp_swap(v, 4'd6, 4'd4);
      v = cmp_swap(v, 4'd4, 4'd2);
      return v[4];
   endfunction

endpackage

/* hdl/rgb_median_3x3_filter.sv */
// Top level of the RGB 3x3 median filter: line-store memory, window, median pipeline, output skid.
// Depends on rmf_pkg.
//
//   channel | direction | tdata / data                              | sideband
//   req_    | in        | [7:0] red [15:8] green [23:16] blue       | tuser = frame_start
//   rsp_    | out       | [7:0] red [15:8] green [23:16] blue,      | tlast = frame_end
//           |           | [33:24] column [45:34] row, zero above    |
//   csr_    | in        | index 0 frame_width, 1 frame_height       | always ready
//
// One pixel is taken every cycle while the skid register is empty; the line memory is read at
// the transfer and written back from stage 1, with forwarding when the same column comes round again.
// After its pixel's transfer a result passes stage 1, the window, stages 3 and 4 and the output register.
// Reset clears counters, window and valid flags; the line memory keeps no reset value.
// When rsp_tready is low a skid register takes one more result, then req_tready falls.
module rgb_median_3x3_filter
   import rmf_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [23:0]               req_tdata,  // pixel_red, pixel_green, pixel_blue
   input  logic                      req_tuser,  // frame_start
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,  // median_red, median_green, median_blue,
                                                 // centre_column, centre_row, zero fill
   output logic                      rsp_tlast,  // frame_end
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam int ADDR_W     = $clog2(MAX_LINE_WIDTH);
   localparam int CMP_W      = (ADDR_W + 1 > FRAME_WIDTH_W) ? ADDR_W + 1 : FRAME_WIDTH_W;
   localparam int COL_WIDE_W = (ADDR_W > CENTRE_COL_W) ? ADDR_W : CENTRE_COL_W;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      centre_type        centre;
   } result_type;

   // Configuration registers.
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff;

   // Raster counters.
   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   // Stage 1: pixel waiting for its line-memory read.
   logic              s1_valid_ff;
   logic              s1_emit_ff;
   pixel_type         s1_pix_ff;
   logic [ADDR_W-1:0] s1_addr_ff;
   centre_type        s1_centre_ff;

   line_entry_type    line_mem [MAX_LINE_WIDTH];
   line_entry_type    mem_rd_ff;
   logic              fwd_ff;
   line_entry_type    fwd_data_ff;
   line_entry_type    line_rd;
   line_entry_type    line_wr;

   // Stage 2: window holds a full neighbourhood.
   pixel_type         window_ff [9];
   logic              s2_valid_ff;
   centre_type        s2_centre_ff;
   window_chan_type   win_chan;

   // Stages 3 and 4: median network.
   logic              s3_valid_ff;
   window_chan_type   s3_chan_ff;
   centre_type        s3_centre_ff;
   logic              s4_valid_ff;
   window_chan_type   s4_chan_ff;
   centre_type        s4_centre_ff;
   result_type        pipe_result;

   // Output register and skid.
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;
   logic              skid_valid_ff;
   result_type        skid_data_ff;

   logic                    adv;
   logic                    req_accept;
   logic [CMP_W-1:0]        width_ext;
   logic [CMP_W-1:0]        width_eff;
   logic [ADDR_W-1:0]       last_col;
   logic [ROW_W-1:0]        height_eff;
   logic [ROW_W-1:0]        last_row;
   logic [ADDR_W-1:0]       col_cur;
   logic [ROW_W-1:0]        row_cur;
   logic                    col_wrap;
   logic                    row_wrap;
   logic [COL_WIDE_W-1:0]   col_wide;
   centre_type              centre_cur;
   logic                    emit_cur;
   logic                    fwd_hit;

   assign csr_ready  = 1'b1;
   assign adv        = !skid_valid_ff;
   assign req_tready = adv;
   assign req_accept = req_tvalid && adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata[FRAME_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata[FRAME_HEIGHT_W-1:0];
         endcase
      end
   end

   // Effective frame size: width clamped to the line memory, both at least three.
   always_comb begin
      width_ext = CMP_W'(frame_width_ff);
      if (width_ext < CMP_W'(MIN_FRAME)) begin
         width_eff = CMP_W'(MIN_FRAME);
      end else if (width_ext > CMP_W'(MAX_LINE_WIDTH)) begin
         width_eff = CMP_W'(MAX_LINE_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      last_col = ADDR_W'(width_eff - CMP_W'(1));

      if (frame_height_ff < ROW_W'(MIN_FRAME)) begin
         height_eff = ROW_W'(MIN_FRAME);
      end else begin
         height_eff = frame_height_ff;
      end
      last_row = height_eff - ROW_W'(1);
   end

   always_comb begin
      col_cur  = req_tuser ? '0 : col_ff;
      row_cur  = req_tuser ? '0 : row_ff;
      col_wrap = col_cur >= last_col;
      row_wrap = row_cur >= last_row;
      emit_cur = (col_cur >= ADDR_W'(2)) && (row_cur >= ROW_W'(2));
      col_wide = COL_WIDE_W'(col_cur) - COL_WIDE_W'(1);
      centre_cur.column = col_wide[CENTRE_COL_W-1:0];
      centre_cur.row    = row_cur - ROW_W'(1);
      centre_cur.last   = (col_cur == last_col) && (row_cur == last_row);

      if (col_wrap) begin
         col_in = '0;
         row_in = row_wrap ? '0 : row_cur + ROW_W'(1);
      end else begin
         col_in = col_cur + ADDR_W'(1);
         row_in = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // The entry the pixel in stage 1 writes back is the one a following pixel
   // at the same column must see; the memory cannot give it yet, so it is forwarded.
   assign fwd_hit = s1_valid_ff && (s1_addr_ff == col_cur);
   assign line_rd = fwd_ff ? fwd_data_ff : mem_rd_ff;

   always_comb begin
      line_wr.upper  = line_rd.middle;
      line_wr.middle = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (adv && s1_valid_ff) begin
         line_mem[s1_addr_ff] <= line_wr;
      end
      if (req_accept) begin
         mem_rd_ff <= line_mem[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         fwd_ff          <= fwd_hit;
         fwd_data_ff     <= line_wr;
         s1_pix_ff.red   <= req_tdata[7:0];
         s1_pix_ff.green <= req_tdata[15:8];
         s1_pix_ff.blue  <= req_tdata[23:16];
         s1_addr_ff      <= col_cur;
         s1_emit_ff      <= emit_cur;
         s1_centre_ff    <= centre_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_accept;
      end
   end

   // Window shift: columns move left, the new right-hand column comes from the line memory and the stage-1 pixel.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            window_ff[i] <= '0;
         end
      end else if (adv && s1_valid_ff) begin
         window_ff[0] <= window_ff[1];
         window_ff[1] <= window_ff[2];
         window_ff[2] <= line_rd.upper;
         window_ff[3] <= window_ff[4];
         window_ff[4] <= window_ff[5];
         window_ff[5] <= line_rd.middle;
         window_ff[6] <= window_ff[7];
         window_ff[7] <= window_ff[8];
         window_ff[8] <= s1_pix_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 9; i++) begin
         win_chan.red[i]   = window_ff[i].red;
         win_chan.green[i] = window_ff[i].green;
         win_chan.blue[i]  = window_ff[i].blue;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_centre_ff     <= s1_centre_ff;
         s3_chan_ff.red   <= med_layers_a(win_chan.red);
         s3_chan_ff.green <= med_layers_a(win_chan.green);
         s3_chan_ff.blue  <= med_layers_a(win_chan.blue);
         s3_centre_ff     <= s2_centre_ff;
         s4_chan_ff.red   <= med_layers_b(s3_chan_ff.red);
         s4_chan_ff.green <= med_layers_b(s3_chan_ff.green);
         s4_chan_ff.blue  <= med_layers_b(s3_chan_ff.blue);
         s4_centre_ff     <= s3_centre_ff;
      end
   end

   always_comb begin
      pipe_result.red    = med_layers_c(s4_chan_ff.red);
      pipe_result.green  = med_layers_c(s4_chan_ff.green);
      pipe_result.blue   = med_layers_c(s4_chan_ff.blue);
      pipe_result.centre = s4_centre_ff;
   end

   // Output register with skid: while the skid is full the pipeline holds.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= s4_valid_ff;
         end
      end else if (adv && s4_valid_ff) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : pipe_result;
      end else if (adv && s4_valid_ff) begin
         skid_data_ff <= pipe_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.centre.last;
   assign rsp_tdata  = {2'b00, rsp_data_ff.centre.row, rsp_data_ff.centre.column,
                        rsp_data_ff.blue, rsp_data_ff.green, rsp_data_ff.red};

endmodule
